FILE: src/fbpa_pkg.sv
// Shared types and constants of the fixed block pool allocator.
// Used by fbpa_ctrl, fbpa_dp and fixed_block_pool_allocator; no dependencies.
`default_nettype none

package fbpa_pkg;

   // Field widths
   localparam int MODE_W = 2;
   localparam int IDX_W  = 10;
   localparam int CNT_W  = 11;
   localparam int SIZE_W = 13;
   localparam int OFF_W  = 22;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_OBTAIN  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RESET   = 2'd2;

   // Register indexes
   localparam logic CSR_POOL_BLOCKS = 1'b0;
   localparam logic CSR_BLOCK_BYTES = 1'b1;

   // Register reset values and block size limits
   localparam int COUNT_RESET = 1024;
   localparam int SIZE_RESET  = 4;
   localparam int SIZE_MIN    = 4;
   localparam int SIZE_MAX    = 4096;

   // Controller to datapath commands
   typedef struct packed {
      logic load;   // capture the incoming item
      logic exec;   // run the held item and load the result fields
      logic link;   // take the next link as the new head
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic need_link;  // held obtain leaves a nonempty list
   } dp_status_type;

endpackage

`default_nettype wire

FILE: src/fbpa_ctrl.sv
// Controller of the fixed block pool allocator: handshakes and sequencing.
// Depends on fbpa_pkg.
`default_nettype none

module fbpa_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output fbpa_pkg::dp_cmd_type        cmd,
   input  wire fbpa_pkg::dp_status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_LINK = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      in_valid_ff, in_valid_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;
   logic      exec;
   logic      load;

   // Result slot is free when empty or taken at this edge
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign exec       = (state_ff == ST_IDLE) && in_valid_ff && slot_free;
   assign req_tready = !in_valid_ff || exec;
   assign load       = req_tvalid && req_tready;

   assign cmd.load = load;
   assign cmd.exec = exec;
   assign cmd.link = (state_ff == ST_LINK);

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      in_valid_in  = in_valid_ff;
      if (load) begin
         in_valid_in = 1'b1;
      end else if (exec) begin
         in_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (exec) begin
               rsp_valid_in = !status.need_link;
               if (status.need_link) begin
                  state_in = ST_LINK;
               end
            end else if (rsp_tready) begin
               rsp_valid_in = 1'b0;
            end
         end
         ST_LINK: begin
            // slot was emptied when the item ran
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/fbpa_dp.sv
// Datapath of the fixed block pool allocator: free list store, head and
// counters, result registers. Depends on fbpa_pkg.
`default_nettype none

module fbpa_dp #(
   parameter int MAX_BLOCKS = 1024
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire fbpa_pkg::dp_cmd_type           cmd,
   output fbpa_pkg::dp_status_type             status,
   input  wire logic [fbpa_pkg::MODE_W-1:0]    req_mode,
   input  wire logic [fbpa_pkg::IDX_W-1:0]     req_block_index,
   input  wire logic [fbpa_pkg::CNT_W-1:0]     eff_count,
   input  wire logic [fbpa_pkg::SIZE_W-1:0]    eff_size,
   output logic                                rsp_granted,
   output logic [fbpa_pkg::IDX_W-1:0]          rsp_given_index,
   output logic [fbpa_pkg::OFF_W-1:0]          rsp_byte_offset,
   output logic [fbpa_pkg::CNT_W-1:0]          rsp_free_left,
   output logic                                rsp_bad_release
);

   localparam int CW = fbpa_pkg::CNT_W;
   localparam int IW = fbpa_pkg::IDX_W;
   localparam int SW = fbpa_pkg::SIZE_W;
   localparam int OW = fbpa_pkg::OFF_W;
   localparam int AW = $clog2(MAX_BLOCKS);
   localparam logic [CW-1:0] RESET_FREE = (MAX_BLOCKS < fbpa_pkg::COUNT_RESET) ?
      CW'(MAX_BLOCKS) : CW'(fbpa_pkg::COUNT_RESET);

   // Free list store
   logic [CW-1:0] link_mem [MAX_BLOCKS];
   logic [CW-1:0] link_rdata_ff;
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [CW-1:0] mem_wdata;

   logic [fbpa_pkg::MODE_W-1:0] mode_ff;
   logic [IW-1:0]               index_ff;
   logic [CW-1:0]               head_ff, head_in;
   logic [CW-1:0]               free_ff, free_in;
   logic [CW-1:0]               init_ff, init_in;
   logic                        fwd_ff, fwd_in;

   logic                        granted_in, bad_in;
   logic [IW-1:0]               given_in;
   logic [OW-1:0]               offset_in;
   logic [CW-1:0]               left_in;

   logic                        is_obtain, is_release, is_reset;
   logic                        init_do, grant, rel_bad;
   logic [CW-1:0]               free_dec;
   logic [CW+SW-1:0]            product;

   assign is_obtain  = (mode_ff == fbpa_pkg::MODE_OBTAIN);
   assign is_release = (mode_ff == fbpa_pkg::MODE_RELEASE);
   assign is_reset   = (mode_ff == fbpa_pkg::MODE_RESET);

   assign init_do  = (init_ff < eff_count);
   assign grant    = (free_ff != '0) && (head_ff < eff_count);
   assign free_dec = free_ff - CW'(1);
   assign rel_bad  = ({1'b0, index_ff} >= eff_count) || (free_ff >= eff_count);
   assign product  = (CW+SW)'(head_ff) * (CW+SW)'(eff_size);

   assign status.need_link = is_obtain && grant && (free_dec != '0);

   // One write a cycle: lazy init on obtain, push on release
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = AW'(init_ff);
      mem_wdata = init_ff + CW'(1);
      if (cmd.exec && is_obtain && init_do) begin
         mem_we = 1'b1;
      end else if (cmd.exec && is_release && !rel_bad) begin
         mem_we    = 1'b1;
         mem_waddr = AW'(index_ff);
         mem_wdata = (free_ff == '0) ? eff_count : head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      link_rdata_ff <= link_mem[AW'(head_ff)];
   end

   // Pool state and result fields
   always_comb begin
      head_in    = head_ff;
      free_in    = free_ff;
      init_in    = init_ff;
      fwd_in     = fwd_ff;
      granted_in = 1'b0;
      given_in   = '0;
      offset_in  = '0;
      bad_in     = 1'b0;
      left_in    = free_ff;
      if (cmd.link) begin
         // entry written by lazy init this request is not yet in the read data
         head_in = fwd_ff ? (head_ff + CW'(1)) : link_rdata_ff;
      end else if (cmd.exec) begin
         if (is_obtain) begin
            fwd_in = init_do && (head_ff == init_ff);
            if (init_do) begin
               init_in = init_ff + CW'(1);
            end
            if (grant) begin
               granted_in = 1'b1;
               given_in   = head_ff[IW-1:0];
               offset_in  = product[OW-1:0];
               free_in    = free_dec;
               left_in    = free_dec;
               if (free_dec == '0) begin
                  head_in = eff_count;
               end
            end
         end else if (is_release) begin
            if (rel_bad) begin
               bad_in = 1'b1;
            end else begin
               head_in = {1'b0, index_ff};
               free_in = free_ff + CW'(1);
               left_in = free_ff + CW'(1);
            end
         end else if (is_reset) begin
            head_in = '0;
            free_in = eff_count;
            init_in = '0;
            left_in = eff_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         free_ff <= RESET_FREE;
         init_ff <= '0;
         fwd_ff  <= 1'b0;
      end else begin
         head_ff <= head_in;
         free_ff <= free_in;
         init_ff <= init_in;
         fwd_ff  <= fwd_in;
      end
   end

   // Held item and result payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_mode;
         index_ff <= req_block_index;
      end
      if (cmd.exec) begin
         rsp_granted     <= granted_in;
         rsp_given_index <= given_in;
         rsp_byte_offset <= offset_in;
         rsp_free_left   <= left_in;
         rsp_bad_release <= bad_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: ports, configuration registers,
// controller and datapath. Depends on fbpa_pkg, fbpa_ctrl and fbpa_dp.
`default_nettype none

// Fixed block pool allocator. Hands out and takes back blocks of equal size
// from a pool of up to MAX_BLOCKS blocks, chained through an embedded free
// list that is built lazily, one entry per obtain, so neither reset nor a
// pool reset request needs a clearing pass. Each request (obtain, release or
// reset the pool) yields exactly one result item: the granted flag, the block
// index and its byte offset from the pool base, the free count afterwards and
// a flag for a rejected release. An item is held in an input register and run
// when the controller is idle and the result slot is free; release, pool reset,
// an unused mode and an obtain that empties the pool or finds it empty finish
// when run, and an obtain that leaves blocks free then passes the link state,
// since the next link of the head comes from a registered list memory read.
// The input register takes a new item while the result register waits to be
// drained. The user must write the block count and block size registers
// through the csr port only while no request is in flight; the block does not
// enforce this. The count is clamped to MAX_BLOCKS and the size to 4..4096. A
// new count applies from the next request on, but the list is rebuilt only by
// a pool reset.
module fixed_block_pool_allocator #(
   parameter int MAX_BLOCKS = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // mode [1:0], block_index [11:2], zero pad
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // granted [0], given_index [10:1],
                                         // byte_offset [32:11], free_left [43:33],
                                         // bad_release [44], zero pad
   // configuration write port
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [12:0] csr_wdata
);

   localparam int CW = fbpa_pkg::CNT_W;
   localparam int SW = fbpa_pkg::SIZE_W;
   localparam int IW = fbpa_pkg::IDX_W;
   localparam int OW = fbpa_pkg::OFF_W;
   localparam int MW = fbpa_pkg::MODE_W;

   logic [CW-1:0] pool_blocks_ff;
   logic [SW-1:0] block_bytes_ff;
   logic [CW-1:0] eff_count;
   logic [SW-1:0] eff_size;

   fbpa_pkg::dp_cmd_type    cmd;
   fbpa_pkg::dp_status_type status;

   logic          rsp_granted;
   logic [IW-1:0] rsp_given_index;
   logic [OW-1:0] rsp_byte_offset;
   logic [CW-1:0] rsp_free_left;
   logic          rsp_bad_release;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pool_blocks_ff <= CW'(fbpa_pkg::COUNT_RESET);
         block_bytes_ff <= SW'(fbpa_pkg::SIZE_RESET);
      end else if (csr_we) begin
         if (csr_addr == fbpa_pkg::CSR_POOL_BLOCKS) begin
            pool_blocks_ff <= csr_wdata[CW-1:0];
         end else begin
            block_bytes_ff <= csr_wdata[SW-1:0];
         end
      end
   end

   // Clamp the count to the pool depth and the size to its legal range
   assign eff_count = (32'(pool_blocks_ff) < MAX_BLOCKS) ? pool_blocks_ff
                                                         : CW'(MAX_BLOCKS);
   always_comb begin
      if (block_bytes_ff < SW'(fbpa_pkg::SIZE_MIN)) begin
         eff_size = SW'(fbpa_pkg::SIZE_MIN);
      end else if (block_bytes_ff > SW'(fbpa_pkg::SIZE_MAX)) begin
         eff_size = SW'(fbpa_pkg::SIZE_MAX);
      end else begin
         eff_size = block_bytes_ff;
      end
   end

   fbpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   fbpa_dp #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_mode        (req_tdata[MW-1:0]),
      .req_block_index (req_tdata[MW+IW-1:MW]),
      .eff_count       (eff_count),
      .eff_size        (eff_size),
      .rsp_granted     (rsp_granted),
      .rsp_given_index (rsp_given_index),
      .rsp_byte_offset (rsp_byte_offset),
      .rsp_free_left   (rsp_free_left),
      .rsp_bad_release (rsp_bad_release)
   );

   // Pack result fields, lowest field first
   assign rsp_tdata = {3'b000, rsp_bad_release, rsp_free_left, rsp_byte_offset,
                       rsp_given_index, rsp_granted};

endmodule

`default_nettype wire
